[rtl/handle_table_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Handle table allocator assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef HANDLE_TABLE_ALLOCATOR_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define HTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("handle table allocator assertion failed");
// Next-cycle implication.
`define HTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("handle table allocator assertion failed");
`else
`define HTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/hta_pkg.sv]
// ----------------------------------------------------------------------------
// Handle table allocator package
// Opcodes, status codes, field widths and the controller command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hta_pkg;

  localparam int HANDLE_W = 11;
  localparam int SIZE_W   = 32;
  localparam int REF_W    = 16;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_SIZE    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_LOCK    = 3'd3,
    OP_UNLOCK  = 3'd4
  } hta_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_ALLOC = 3'd3,
    ST_STILL_REF = 3'd4
  } hta_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // latch the request and read its table entry
    logic commit;  // write the entry back, update the list, load the result
  } hta_cmd_t;

endpackage

`default_nettype wire

[rtl/hta_ctrl.sv]
// ----------------------------------------------------------------------------
// Handle table allocator controller
// Two-state sequencer: take a request, then commit it once the result
// register can take the answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hta_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output hta_pkg::hta_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } hta_state_t;

  hta_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       exec_go;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // The result register is free when empty or when its transaction completes now.
  assign exec_go    = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign cmd.accept = in_tvalid && in_tready;
  assign cmd.commit = exec_go;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/hta_datapath.sv]
// ----------------------------------------------------------------------------
// Handle table allocator datapath
// Entry memories, free-list head, high-water mark and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hta_datapath #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire hta_pkg::hta_cmd_t               cmd,
  input  wire logic [hta_pkg::OP_W-1:0]        in_opcode,
  input  wire logic [hta_pkg::HANDLE_W-1:0]    in_handle,
  input  wire logic [hta_pkg::SIZE_W-1:0]      in_alloc_size,
  output logic      [hta_pkg::HANDLE_W-1:0]    out_new_handle,
  output logic      [hta_pkg::SIZE_W-1:0]      out_size_out,
  output logic      [hta_pkg::STATUS_W-1:0]    out_status
);

  localparam int LW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

  // Entry storage, one array per field, all at the same address.
  logic [LW-1:0]                mem_link  [ENTRIES];
  logic [hta_pkg::SIZE_W-1:0]   mem_bytes [ENTRIES];
  logic [hta_pkg::REF_W-1:0]    mem_ref   [ENTRIES];
  logic                         mem_used  [ENTRIES];

  // Control state.
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] hw_r, hw_nxt;

  // Latched request and entry read data.
  logic [hta_pkg::OP_W-1:0]     op_r;
  logic                         handle_zero_r;
  logic                         hvalid_r;
  logic [hta_pkg::SIZE_W-1:0]   size_r;
  logic [AW-1:0]                addr_r;
  logic [LW-1:0]                rd_link_r;
  logic [hta_pkg::SIZE_W-1:0]   rd_size_r;
  logic [hta_pkg::REF_W-1:0]    rd_ref_r;
  logic                         rd_used_r;

  // Result register.
  logic [hta_pkg::HANDLE_W-1:0] nh_r;
  logic [hta_pkg::SIZE_W-1:0]   so_r;
  logic [hta_pkg::STATUS_W-1:0] st_r;

  logic                         hvalid_in;
  logic [hta_pkg::HANDLE_W-1:0] handle_m1;
  logic [AW-1:0]                addr_in;
  logic                         head_empty;

  logic                         fresh;
  logic                         used;
  logic [LW-1:0]                addr_ext;
  logic [LW-1:0]                addr_inc;
  logic [LW-1:0]                link_eff;
  hta_pkg::hta_status_t         lookup_st;

  logic [hta_pkg::HANDLE_W-1:0] nh;
  logic [hta_pkg::SIZE_W-1:0]   so;
  hta_pkg::hta_status_t         st;
  logic                         wr_link, wr_size, wr_ref, wr_used;
  logic [LW-1:0]                link_data;
  logic [hta_pkg::REF_W-1:0]    ref_data;
  logic                         used_data;

  assign head_empty = (free_head_r >= NULL_LINK);

  // Request decode and read address.
  always_comb begin
    hvalid_in = (in_handle != '0) && (32'(in_handle) <= 32'(ENTRIES));
    handle_m1 = in_handle - hta_pkg::HANDLE_W'(1);
    if (in_opcode == hta_pkg::OP_ALLOC) begin
      addr_in = head_empty ? '0 : AW'(free_head_r);
    end else begin
      addr_in = hvalid_in ? AW'(handle_m1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r          <= in_opcode;
      handle_zero_r <= (in_handle == '0);
      hvalid_r      <= hvalid_in;
      size_r        <= in_alloc_size;
      addr_r        <= addr_in;
      rd_link_r     <= mem_link[addr_in];
      rd_size_r     <= mem_bytes[addr_in];
      rd_ref_r      <= mem_ref[addr_in];
      rd_used_r     <= mem_used[addr_in];
    end
  end

  // Slots at or above the high-water mark were never allocated: they are
  // free and still link to the next index.
  always_comb begin
    addr_ext  = LW'(addr_r);
    addr_inc  = addr_ext + LW'(1);
    fresh     = (addr_ext >= hw_r);
    used      = !fresh && rd_used_r;
    link_eff  = fresh ? addr_inc : rd_link_r;
    if (!hvalid_r) begin
      lookup_st = hta_pkg::ST_RANGE;
    end else if (!used) begin
      lookup_st = hta_pkg::ST_NOT_ALLOC;
    end else begin
      lookup_st = hta_pkg::ST_OK;
    end
  end

  always_comb begin
    nh            = '0;
    so            = '0;
    st            = hta_pkg::ST_OK;
    wr_link       = 1'b0;
    wr_size       = 1'b0;
    wr_ref        = 1'b0;
    wr_used       = 1'b0;
    link_data     = free_head_r;
    ref_data      = rd_ref_r;
    used_data     = 1'b0;
    free_head_nxt = free_head_r;
    hw_nxt        = hw_r;
    case (op_r)
      hta_pkg::OP_ALLOC: begin
        if (head_empty) begin
          st = hta_pkg::ST_NO_FREE;
        end else begin
          nh            = hta_pkg::HANDLE_W'(addr_inc);
          wr_used       = 1'b1;
          used_data     = 1'b1;
          wr_size       = 1'b1;
          wr_ref        = 1'b1;
          ref_data      = '0;
          free_head_nxt = link_eff;
          if (fresh) begin
            hw_nxt = addr_inc;
          end
        end
      end
      hta_pkg::OP_SIZE: begin
        st = lookup_st;
        if (lookup_st == hta_pkg::ST_OK) begin
          so = rd_size_r;
        end
      end
      hta_pkg::OP_RELEASE: begin
        if (!handle_zero_r) begin
          st = lookup_st;
          if (lookup_st == hta_pkg::ST_OK) begin
            if (rd_ref_r != '0) begin
              st = hta_pkg::ST_STILL_REF;
            end else begin
              wr_used       = 1'b1;
              used_data     = 1'b0;
              wr_link       = 1'b1;
              link_data     = free_head_r;
              free_head_nxt = addr_ext;
            end
          end
        end
      end
      hta_pkg::OP_LOCK: begin
        st = lookup_st;
        if ((lookup_st == hta_pkg::ST_OK) && (rd_ref_r != hta_pkg::REF_MAX)) begin
          wr_ref   = 1'b1;
          ref_data = rd_ref_r + hta_pkg::REF_W'(1);
        end
      end
      hta_pkg::OP_UNLOCK: begin
        st = lookup_st;
        if ((lookup_st == hta_pkg::ST_OK) && (rd_ref_r != '0)) begin
          wr_ref   = 1'b1;
          ref_data = rd_ref_r - hta_pkg::REF_W'(1);
        end
      end
      default: begin
        st = hta_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (wr_link) begin
        mem_link[addr_r] <= link_data;
      end
      if (wr_size) begin
        mem_bytes[addr_r] <= size_r;
      end
      if (wr_ref) begin
        mem_ref[addr_r] <= ref_data;
      end
      if (wr_used) begin
        mem_used[addr_r] <= used_data;
      end
      nh_r <= nh;
      so_r <= so;
      st_r <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      hw_r        <= '0;
    end else if (cmd.commit) begin
      free_head_r <= free_head_nxt;
      hw_r        <= hw_nxt;
    end
  end

  assign out_new_handle = nh_r;
  assign out_size_out   = so_r;
  assign out_status     = st_r;

endmodule

`default_nettype wire

[rtl/handle_table_allocator.sv]
// Handle table allocator.
// Requests arrive on the in_ stream: the opcode in in_tuser selects allocate,
// get size, release, lock or unlock, and in_tdata carries the handle and the
// allocation size. Every accepted request yields exactly one result
// transaction on the out_ stream with the new handle, the recorded size and
// a status code.
// A request is read from the entry memories at the edge that accepts it and
// committed from the S_EXEC state once the result register can take the
// answer. One request is handled at a time; the next one is accepted only
// after the commit, when the controller is back in S_IDLE.
// A result waiting in the output register does not block the next request;
// only its commit waits while out_tready is low and the register is full.
// Reset (synchronous, rst_n low) empties the output register and rebuilds
// the free list in index order at once through a high-water mark, so no
// clearing pass is needed and requests are accepted right after reset.
// ----------------------------------------------------------------------------
// Handle table allocator top level
// Connects the controller and the datapath to the request and result streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "handle_table_allocator_defines.svh"

module handle_table_allocator #(
  parameter int ENTRIES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [10:0] handle, [42:11] alloc_size, rest zero
  input  wire logic [2:0]  in_tuser,   // [2:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // [10:0] new_handle, [42:11] size_out,
                                       // [45:43] status, rest zero
);

  hta_pkg::hta_cmd_t               cmd;
  logic [hta_pkg::HANDLE_W-1:0]    new_handle;
  logic [hta_pkg::SIZE_W-1:0]      size_out;
  logic [hta_pkg::STATUS_W-1:0]    status;

  // The controller sequences each transaction; the datapath owns all tables.
  hta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  hta_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_opcode      (in_tuser),
    .in_handle      (in_tdata[10:0]),
    .in_alloc_size  (in_tdata[42:11]),
    .out_new_handle (new_handle),
    .out_size_out   (size_out),
    .out_status     (status)
  );

  assign out_tdata = {2'b00, status, size_out, new_handle};

  // A request is committed only after the cycle that accepted it, and only
  // one request is in flight at a time.
  `HTA_ASSERT_NXT(a_single_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `HTA_ASSERT_IMP(a_commit_not_idle, clk, rst_n, cmd.commit, !in_tready)
  `HTA_ASSERT_NXT(a_commit_gives_result, clk, rst_n, cmd.commit, out_tvalid)

endmodule

`default_nettype wire

[tb/tb_handle_table_allocator.sv]
// ----------------------------------------------------------------------------
// Handle table allocator testbench
// Streams allocate, get size, release, lock and unlock requests into the
// block and checks every result transaction against a behavioral model of
// the handle table that the testbench keeps alongside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_handle_table_allocator;

  localparam int ENTRIES      = 1024;
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 5;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1200000;
  localparam int MAX_REPORTS  = 30;

  localparam logic [hta_pkg::HANDLE_W-1:0] HANDLE_MAX  = '1;
  localparam logic [hta_pkg::HANDLE_W-1:0] LAST_HANDLE = hta_pkg::HANDLE_W'(ENTRIES);

  // Opcodes outside the defined set; the block answers them with all zeros.
  localparam logic [hta_pkg::OP_W-1:0] OP_RSVD_LO  = 3'd5;
  localparam logic [hta_pkg::OP_W-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [hta_pkg::OP_W-1:0] OP_RSVD_HI  = 3'd7;

  typedef struct packed {
    logic [hta_pkg::HANDLE_W-1:0] new_handle;
    logic [hta_pkg::SIZE_W-1:0]   size_out;
    logic [hta_pkg::STATUS_W-1:0] status;
  } table_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // [10:0] handle, [42:11] alloc_size, rest zero
  logic [2:0]  in_tuser   = '0;   // [2:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // [10:0] new_handle, [42:11] size_out,
                                  // [45:43] status, rest zero

  handle_table_allocator #(.ENTRIES(ENTRIES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Model of the handle table.
  logic [hta_pkg::HANDLE_W-1:0] free_head;
  logic [hta_pkg::HANDLE_W-1:0] next_link  [0:ENTRIES-1];
  logic                         in_use     [0:ENTRIES-1];
  logic [hta_pkg::SIZE_W-1:0]   entry_size [0:ENTRIES-1];
  logic [hta_pkg::REF_W-1:0]    ref_count  [0:ENTRIES-1];
  logic [hta_pkg::HANDLE_W-1:0] live_handles [$];

  table_result_t pending_results [$];

  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  int          hold_requests      = 0;
  int          hold_served        = 0;
  int          hold_left          = 0;
  int          mismatch_count     = 0;
  int          results_checked    = 0;
  int          request_count      = 0;
  int          reserved_count     = 0;
  int          status_count [0:7];
  bit          saturation_seen    = 1'b0;
  int unsigned cycle_count        = 0;

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  function automatic logic [hta_pkg::STATUS_W-1:0] check_handle(
      input logic [hta_pkg::HANDLE_W-1:0] h);
    if (h == 0 || h > ENTRIES) begin
      return hta_pkg::ST_RANGE;
    end
    if (!in_use[h - 1'b1]) begin
      return hta_pkg::ST_NOT_ALLOC;
    end
    return hta_pkg::ST_OK;
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic table_result_t predict_table_op(
      input logic [hta_pkg::OP_W-1:0]     op,
      input logic [hta_pkg::HANDLE_W-1:0] h,
      input logic [hta_pkg::SIZE_W-1:0]   sz);
    table_result_t r;
    int            slot;
    r = '0;
    request_count++;
    case (op)
      hta_pkg::OP_ALLOC: begin
        if (free_head >= ENTRIES) begin
          r.status = hta_pkg::ST_NO_FREE;
        end else begin
          slot             = free_head;
          free_head        = next_link[slot];
          in_use[slot]     = 1'b1;
          entry_size[slot] = sz;
          ref_count[slot]  = '0;
          r.new_handle     = hta_pkg::HANDLE_W'(slot + 1);
          live_handles.push_back(hta_pkg::HANDLE_W'(slot + 1));
        end
      end
      hta_pkg::OP_SIZE: begin
        r.status = check_handle(h);
        if (r.status == hta_pkg::ST_OK) begin
          r.size_out = entry_size[h - 1'b1];
        end
      end
      hta_pkg::OP_RELEASE: begin
        // Releasing the null handle succeeds and touches nothing.
        if (h != 0) begin
          r.status = check_handle(h);
          if (r.status == hta_pkg::ST_OK) begin
            if (ref_count[h - 1'b1] != 0) begin
              r.status = hta_pkg::ST_STILL_REF;
            end else begin
              in_use[h - 1'b1]    = 1'b0;
              next_link[h - 1'b1] = free_head;
              free_head           = h - 1'b1;
              for (int k = 0; k < live_handles.size(); k++) begin
                if (live_handles[k] == h) begin
                  live_handles.delete(k);
                  break;
                end
              end
            end
          end
        end
      end
      hta_pkg::OP_LOCK: begin
        r.status = check_handle(h);
        if (r.status == hta_pkg::ST_OK) begin
          if (ref_count[h - 1'b1] != hta_pkg::REF_MAX) begin
            ref_count[h - 1'b1] = ref_count[h - 1'b1] + 1'b1;
          end else begin
            saturation_seen = 1'b1;
          end
        end
      end
      hta_pkg::OP_UNLOCK: begin
        r.status = check_handle(h);
        if (r.status == hta_pkg::ST_OK && ref_count[h - 1'b1] != 0) begin
          ref_count[h - 1'b1] = ref_count[h - 1'b1] - 1'b1;
        end
      end
      default: begin
        reserved_count++;
      end
    endcase
    status_count[r.status]++;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one request, holding it until the block takes it, then records the
  // result the model expects. Valid stays high between back-to-back requests.
  task automatic send_request(input  logic [hta_pkg::OP_W-1:0]     op,
                              input  logic [hta_pkg::HANDLE_W-1:0] h,
                              input  logic [hta_pkg::SIZE_W-1:0]   sz,
                              output table_result_t                predicted);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, sz, h};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_table_op(op, h, sz);
    pending_results.push_back(predicted);
  endtask

  function automatic logic [hta_pkg::SIZE_W-1:0] random_size();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [hta_pkg::HANDLE_W-1:0] pick_handle();
    if (live_handles.size() == 0 || $urandom_range(9) == 0) begin
      return hta_pkg::HANDLE_W'($urandom_range(HANDLE_MAX, 0));
    end
    return live_handles[$urandom_range(live_handles.size() - 1)];
  endfunction

  // Mostly requests on handles that are live, so that locks, sizes and
  // releases reach allocated slots; a small share is unconstrained noise.
  task automatic send_random_request();
    table_result_t                r;
    int                           pick;
    logic [hta_pkg::OP_W-1:0]     op;
    logic [hta_pkg::HANDLE_W-1:0] h;
    pick = $urandom_range(99);
    h    = pick_handle();
    if (pick < 30) begin
      op = hta_pkg::OP_ALLOC;
    end else if (pick < 46) begin
      op = hta_pkg::OP_SIZE;
    end else if (pick < 62) begin
      op = hta_pkg::OP_LOCK;
    end else if (pick < 80) begin
      op = hta_pkg::OP_UNLOCK;
    end else if (pick < 93) begin
      op = hta_pkg::OP_RELEASE;
    end else begin
      op = hta_pkg::OP_W'($urandom_range(OP_RSVD_HI, 0));
      h  = hta_pkg::HANDLE_W'($urandom_range(HANDLE_MAX, 0));
    end
    send_request(op, h, random_size(), r);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic compare_field(input string name,
                               input logic [hta_pkg::SIZE_W-1:0] expected,
                               input logic [hta_pkg::SIZE_W-1:0] actual);
    if (expected !== actual) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      end
    end
  endtask

  always @(posedge clk) begin
    table_result_t expected;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with none expected, expected nothing, actual %h",
                   $time, out_tdata);
        end
      end else begin
        expected = pending_results.pop_front();
        results_checked++;
        compare_field("new_handle", hta_pkg::SIZE_W'(expected.new_handle),
                      hta_pkg::SIZE_W'(out_tdata[10:0]));
        compare_field("size_out", expected.size_out, out_tdata[42:11]);
        compare_field("status", hta_pkg::SIZE_W'(expected.status),
                      hta_pkg::SIZE_W'(out_tdata[45:43]));
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Extremes of every field, every opcode and every error path that a fresh table can show.
  task automatic test_directed();
    table_result_t r;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_request(hta_pkg::OP_ALLOC,   '0,          '0, r);   // zero size, handle 1
    send_request(hta_pkg::OP_ALLOC,   HANDLE_MAX,  '1, r);   // largest size, handle 2
    send_request(hta_pkg::OP_SIZE,    11'd1,       '1, r);
    send_request(hta_pkg::OP_SIZE,    11'd2,       '0, r);
    send_request(hta_pkg::OP_SIZE,    '0,          '0, r);   // null handle
    send_request(hta_pkg::OP_SIZE,    LAST_HANDLE + 1'b1, '0, r); // just past the table
    send_request(hta_pkg::OP_LOCK,    HANDLE_MAX,  '0, r);
    send_request(hta_pkg::OP_UNLOCK,  '0,          '0, r);
    send_request(hta_pkg::OP_SIZE,    11'd3,       '0, r);   // slot never allocated
    send_request(hta_pkg::OP_LOCK,    11'd3,       '0, r);
    send_request(hta_pkg::OP_UNLOCK,  LAST_HANDLE, '0, r);
    send_request(hta_pkg::OP_RELEASE, '0,          '1, r);   // null release is fine
    send_request(hta_pkg::OP_RELEASE, HANDLE_MAX,  '0, r);
    send_request(hta_pkg::OP_RELEASE, LAST_HANDLE, '0, r);
    send_request(hta_pkg::OP_LOCK,    11'd2,       '0, r);
    send_request(hta_pkg::OP_RELEASE, 11'd2,       '0, r);   // still referenced
    send_request(hta_pkg::OP_UNLOCK,  11'd2,       '0, r);
    send_request(hta_pkg::OP_UNLOCK,  11'd2,       '0, r);   // already at zero
    send_request(hta_pkg::OP_RELEASE, 11'd2,       '0, r);
    send_request(hta_pkg::OP_RELEASE, 11'd2,       '0, r);   // released twice
    send_request(OP_RSVD_LO,          HANDLE_MAX,  '1, r);
    send_request(OP_RSVD_MID,         11'd1,       '1, r);
    send_request(OP_RSVD_HI,          '0,          '0, r);
    send_request(hta_pkg::OP_ALLOC,   '0,    $urandom, r);   // reuses handle 2
  endtask

  // Counts one slot's references up and down to zero, then unlocks once more;
  // a release is refused while any reference is held and allowed once it is zero.
  task automatic test_ref_count();
    table_result_t                r;
    logic [hta_pkg::HANDLE_W-1:0] h;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_request(hta_pkg::OP_ALLOC, '0, random_size(), r);
    h = r.new_handle;
    repeat (5) send_request(hta_pkg::OP_LOCK, h, $urandom, r);
    send_request(hta_pkg::OP_RELEASE, h, '0, r);
    repeat (4) send_request(hta_pkg::OP_UNLOCK, h, $urandom, r);
    send_request(hta_pkg::OP_RELEASE, h, '0, r);   // one reference left
    repeat (2) send_request(hta_pkg::OP_UNLOCK, h, '0, r);
    send_request(hta_pkg::OP_RELEASE, h, '0, r);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_random_request();
  endtask

  // The receiver holds off while requests keep coming, so the result
  // register fills and the block must stop taking requests.
  task automatic test_output_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_requests++;
    repeat (40) send_random_request();
  endtask

  // Frees a few live slots and takes them back, so the list hands them out
  // last in, first out.
  task automatic test_free_list_reuse();
    table_result_t                r;
    logic [hta_pkg::HANDLE_W-1:0] h;
    sender_idle_pct    = 25;
    receiver_stall_pct = 25;
    repeat (4) begin
      if (live_handles.size() != 0) begin
        h = live_handles[$urandom_range(live_handles.size() - 1)];
        while (ref_count[h - 1'b1] != 0) send_request(hta_pkg::OP_UNLOCK, h, $urandom, r);
        send_request(hta_pkg::OP_RELEASE, h, $urandom, r);
      end
    end
    repeat (5) send_request(hta_pkg::OP_ALLOC, '0, random_size(), r);
  endtask

  initial begin
    free_head = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      next_link[i]  = hta_pkg::HANDLE_W'(i + 1);
      in_use[i]     = 1'b0;
      entry_size[i] = '0;
      ref_count[i]  = '0;
    end
    for (int i = 0; i < 8; i++) begin
      status_count[i] = 0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_ref_count();
    test_random_traffic(120, 0, 0);
    test_random_traffic(120, 68, 0);
    test_output_backpressure();
    test_random_traffic(120, 0, 68);
    test_random_traffic(120, 25, 25);
    test_free_list_reuse();

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d requests: %0d ok, %0d on an empty table,",
             results_checked, request_count, status_count[hta_pkg::ST_OK],
             status_count[hta_pkg::ST_NO_FREE]);
    $display("%0d out of range, %0d on free slots, %0d held by references, %0d reserved %s",
             status_count[hta_pkg::ST_RANGE], status_count[hta_pkg::ST_NOT_ALLOC],
             status_count[hta_pkg::ST_STILL_REF], reserved_count,
             saturation_seen ? "(count saturated)" : "(no saturation)");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
